// ===== src/bts_pkg.sv =====
// ---------------------------------------------------------------------------
// bts_pkg
// Types, codes and helpers shared by the sighting table block.
// ---------------------------------------------------------------------------
package bts_pkg;

   // Width of the slot index carried by a search beat.
   localparam int SLOT_W = 8;

   // Result status codes.
   localparam logic [2:0] ST_NOT_TRACKER = 3'd0;
   localparam logic [2:0] ST_UPDATED     = 3'd1;
   localparam logic [2:0] ST_INSERTED    = 3'd2;
   localparam logic [2:0] ST_DROPPED     = 3'd3;
   localparam logic [2:0] ST_CLEARED     = 3'd4;

   // Configuration register indexes.
   localparam logic [1:0] CSR_COUNT_THR = 2'd0;
   localparam logic [1:0] CSR_SPAN_THR  = 2'd1;
   localparam logic [1:0] CSR_LIMIT     = 2'd2;

   // Company identifiers and subtypes.
   localparam logic [15:0] CO_KIND0   = 16'h004C;
   localparam logic [15:0] CO_KIND1   = 16'h0097;
   localparam logic [15:0] CO_KIND2   = 16'h0075;
   localparam logic [15:0] CO_KIND3   = 16'h0349;
   localparam logic [7:0]  SUB_A      = 8'h12;
   localparam logic [7:0]  SUB_B      = 8'h07;

   typedef struct packed {
      logic              cmd;
      logic [7:0]        mfg_length;
      logic [15:0]       company_id;
      logic [7:0]        vendor_subtype;
      logic [47:0]       device_address;
      logic signed [7:0] signal_dbm;
      logic [31:0]       time_ms;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [1:0]  tracker_kind;
      logic [5:0]  slot;
      logic [15:0] sighting_count;
      logic        is_persistent;
      logic [6:0]  entries_used;
   } rsp_type;

   // One search beat walking down the chain of cells.
   typedef struct packed {
      logic              valid;
      logic              hit;
      logic [47:0]       addr;
      logic [31:0]       now;
      logic [SLOT_W-1:0] slot;
      logic [15:0]       count;
      logic [31:0]       span;
   } token_type;

   // Classification: bit 2 set means a tracker, bits 1:0 the kind.
   function automatic logic [2:0] classify(input logic [7:0] len,
                                           input logic [15:0] co,
                                           input logic [7:0] sub);
      logic [2:0] r;
      r = 3'b000;
      if (len >= 8'd2) begin
         if (co == CO_KIND0) begin
            if (len >= 8'd3 && (sub == SUB_A || sub == SUB_B)) r = 3'b100;
         end else if (co == CO_KIND1) begin
            r = 3'b101;
         end else if (co == CO_KIND2) begin
            r = 3'b110;
         end else if (co == CO_KIND3) begin
            r = 3'b111;
         end
      end
      return r;
   endfunction

endpackage

// ===== src/bts_stream_if.sv =====
// ---------------------------------------------------------------------------
// bts_stream_if
// Valid/ready channel carrying one payload per beat.
// ---------------------------------------------------------------------------
interface bts_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/bts_cell.sv =====
// ---------------------------------------------------------------------------
// bts_cell
// One table entry; compares and updates as a search beat passes through.
// ---------------------------------------------------------------------------
module bts_cell
   import bts_pkg::*;
#(
   parameter int IDX = 0,
   parameter int CW  = 7
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [CW-1:0] entry_cnt,
   input  token_type     tok_in,
   output token_type     tok_out,
   input  logic          ins_en,
   input  logic [CW-1:0] ins_idx,
   input  logic [47:0]   ins_addr,
   input  logic [31:0]   ins_time
);

   logic [47:0] addr_ff;
   logic [31:0] first_ff;
   logic [15:0] count_ff;
   token_type   tok_ff;
   token_type   tok_in_w;
   logic        match;

   // A live entry whose address equals the beat's address is a hit, unless an earlier cell already hit.
   assign match = tok_in.valid && !tok_in.hit && (32'(entry_cnt) > IDX) &&
                  (addr_ff == tok_in.addr);

   // Next beat: passes through, or carries this entry's updated values.
   always_comb begin
      tok_in_w = tok_in;
      if (match) begin
         tok_in_w.hit   = 1'b1;
         tok_in_w.slot  = SLOT_W'(IDX);
         tok_in_w.count = (count_ff == 16'hFFFF) ? count_ff : count_ff + 16'd1;
         tok_in_w.span  = tok_in.now - first_ff;
      end
   end

   // Beat register.
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_w;
      end
   end

   // Entry storage: written on insert or on a hit.
   always_ff @(posedge clock) begin
      if (ins_en && (32'(ins_idx) == IDX)) begin
         addr_ff  <= ins_addr;
         first_ff <= ins_time;
         count_ff <= 16'd1;
      end else if (match) begin
         count_ff <= tok_in_w.count;
      end
   end

   assign tok_out = tok_ff;

endmodule

// ===== src/ble_tracker_sighting_table_unit.sv =====
// ---------------------------------------------------------------------------
// ble_tracker_sighting_table_unit
// Tracker sighting table built as a chain of entry cells.
// ---------------------------------------------------------------------------
// For a tracker report the search beat walks one cell per cycle down the
// chain of MAX_ENTRIES cells before the result is formed and written to
// the output register. Clear commands and non-tracker reports skip the
// search. One item is in work at a time; a new item is taken once the
// previous result is in the output register. Reset empties the table and
// loads the default thresholds; entry contents are not cleared.
module ble_tracker_sighting_table_unit
   import bts_pkg::*;
#(
   parameter int MAX_ENTRIES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   bts_stream_if.sink            req_chan,
   bts_stream_if.source          rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_wdata
);

   localparam int CW = $clog2(MAX_ENTRIES + 1);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SEARCH = 2'd1;
   localparam logic [1:0] S_DONE   = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [15:0]   cnt_thr_ff;
   logic [31:0]   span_thr_ff;
   logic [6:0]    limit_ff;
   logic [CW-1:0] entry_cnt_ff, entry_cnt_in;
   req_type       item_ff;
   logic [2:0]    cls_ff;
   token_type     res_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff, rsp_in;
   logic          accept, out_free, finish, ins_en, ins_ok;
   logic [2:0]    cls_w;
   token_type     launch_tok;
   token_type     chain [0:MAX_ENTRIES];

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign finish   = (state_ff == S_DONE) && out_free;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign cls_w = classify(req_chan.payload.mfg_length, req_chan.payload.company_id,
                           req_chan.payload.vendor_subtype);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_thr_ff  <= 16'd3;
         span_thr_ff <= 32'd300000;
         limit_ff    <= 7'd50;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_COUNT_THR: cnt_thr_ff  <= csr_wdata[15:0];
            CSR_SPAN_THR:  span_thr_ff <= csr_wdata;
            CSR_LIMIT:     limit_ff    <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // Launch beat into the first cell on a tracker report.
   always_comb begin
      launch_tok       = '0;
      launch_tok.valid = accept && !req_chan.payload.cmd && cls_w[2];
      launch_tok.addr  = req_chan.payload.device_address;
      launch_tok.now   = req_chan.payload.time_ms;
   end

   assign chain[0] = launch_tok;

   // Chain of entry cells.
   for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      bts_cell #(.IDX(g), .CW(CW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .entry_cnt (entry_cnt_ff),
         .tok_in    (chain[g]),
         .tok_out   (chain[g+1]),
         .ins_en    (ins_en),
         .ins_idx   (entry_cnt_ff),
         .ins_addr  (item_ff.device_address),
         .ins_time  (item_ff.time_ms)
      );
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = launch_tok.valid ? S_SEARCH : S_DONE;
         end
         S_SEARCH: begin
            if (chain[MAX_ENTRIES].valid) state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Item and search result capture.
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_chan.payload;
         cls_ff  <= cls_w;
         res_ff  <= '0;
      end else if (chain[MAX_ENTRIES].valid) begin
         res_ff <= chain[MAX_ENTRIES];
      end
   end

   // Result forming and insert decision.
   assign ins_ok = (32'(entry_cnt_ff) < 32'(limit_ff)) &&
                   (32'(entry_cnt_ff) < MAX_ENTRIES);
   assign ins_en = finish && !item_ff.cmd && cls_ff[2] && !res_ff.hit && ins_ok;

   always_comb begin
      entry_cnt_in = entry_cnt_ff;
      rsp_in       = '0;
      if (item_ff.cmd) begin
         entry_cnt_in  = '0;
         rsp_in.status = ST_CLEARED;
      end else if (!cls_ff[2]) begin
         rsp_in.status = ST_NOT_TRACKER;
      end else if (res_ff.hit) begin
         rsp_in.status         = ST_UPDATED;
         rsp_in.tracker_kind   = cls_ff[1:0];
         rsp_in.slot           = res_ff.slot[5:0];
         rsp_in.sighting_count = res_ff.count;
         rsp_in.is_persistent  = (res_ff.count >= cnt_thr_ff) ||
                                 (res_ff.span > span_thr_ff);
      end else if (ins_ok) begin
         entry_cnt_in          = entry_cnt_ff + CW'(1);
         rsp_in.status         = ST_INSERTED;
         rsp_in.tracker_kind   = cls_ff[1:0];
         rsp_in.slot           = 6'(entry_cnt_ff);
         rsp_in.sighting_count = 16'd1;
         rsp_in.is_persistent  = (cnt_thr_ff <= 16'd1);
      end else begin
         rsp_in.status       = ST_DROPPED;
         rsp_in.tracker_kind = cls_ff[1:0];
      end
      rsp_in.entries_used = 7'(entry_cnt_in);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         entry_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (finish) begin
            entry_cnt_ff <= entry_cnt_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (finish) rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   // Checks.
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      32'(entry_cnt_ff) <= MAX_ENTRIES)
      else $error("entry count beyond table depth");
   a_exit_search: assert property (@(posedge clock) disable iff (reset)
      chain[MAX_ENTRIES].valid |-> state_ff == S_SEARCH)
      else $error("search beat left the chain outside a search");
   a_launch: assert property (@(posedge clock) disable iff (reset)
      launch_tok.valid |=> state_ff == S_SEARCH)
      else $error("search launched without entering search");
   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      ins_en |=> entry_cnt_ff == $past(entry_cnt_ff) + CW'(1))
      else $error("insert did not grow the table");

endmodule

// ===== tb/tb_ble_tracker_sighting_table_unit.sv =====
// ---------------------------------------------------------------------------
// tb_ble_tracker_sighting_table_unit
// Self-checking bench for the tracker sighting table. A short table of
// directed reports and clears is followed by random traffic over a small
// pool of addresses, so that entries get hit, the table fills and drops,
// and clears empty it again. The thresholds and table limit are moved
// between phases, including their extremes. Each accepted result beat is
// compared field by field against a behavioral copy of the table.
// ---------------------------------------------------------------------------
module tb_ble_tracker_sighting_table_unit;
   import bts_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH  = 64;
   localparam int DRAIN_CYCLES = 100;
   localparam int CYCLE_LIMIT  = 2000000;
   localparam int POOL_SIZE    = 80;

   localparam logic [1:0] KIND_CO0 = 2'd0;
   localparam logic [1:0] KIND_CO1 = 2'd1;
   localparam logic [1:0] KIND_CO2 = 2'd2;
   localparam logic [1:0] KIND_CO3 = 2'd3;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;

   bts_stream_if #(.payload_type(req_type)) req_if ();
   bts_stream_if #(.payload_type(rsp_type)) rsp_if ();

   ble_tracker_sighting_table_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if.sink),
      .rsp_chan  (rsp_if.source),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Clock with a 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Shadow copy of the table and its settings.
   logic [15:0] thr_count;
   logic [31:0] thr_span;
   logic [6:0]  entry_limit;
   int          used_entries;
   logic [47:0] addr_copy  [TABLE_DEPTH];
   logic [31:0] first_copy [TABLE_DEPTH];
   logic [31:0] last_copy  [TABLE_DEPTH];
   logic [15:0] count_copy [TABLE_DEPTH];

   rsp_type     expected_sightings[$];
   int          error_count;
   int          cycle_count;
   bit          hold_rsp;
   logic [47:0] addr_pool [POOL_SIZE];
   logic [31:0] clock_ms;

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type result;
   } vector_row;
   vector_row directed_rows[$];

   // Works out the result of one item and advances the shadow table.
   function automatic rsp_type predict_sighting(req_type it);
      rsp_type     r;
      int          kind;
      int          room;
      logic [31:0] span;
      r = '0;
      if (it.cmd) begin
         used_entries = 0;
         r.status = ST_CLEARED;
         return r;
      end
      kind = -1;
      if (it.mfg_length >= 2) begin
         if (it.company_id == CO_KIND0) begin
            if (it.mfg_length >= 3 &&
                (it.vendor_subtype == SUB_A || it.vendor_subtype == SUB_B))
               kind = KIND_CO0;
         end else if (it.company_id == CO_KIND1) kind = KIND_CO1;
         else if (it.company_id == CO_KIND2) kind = KIND_CO2;
         else if (it.company_id == CO_KIND3) kind = KIND_CO3;
      end
      if (kind < 0) begin
         r.status = ST_NOT_TRACKER;
         r.entries_used = 7'(used_entries);
         return r;
      end
      r.tracker_kind = 2'(kind);
      // Search in insertion order.
      for (int i = 0; i < used_entries; i++) begin
         if (addr_copy[i] == it.device_address) begin
            last_copy[i] = it.time_ms;
            if (count_copy[i] != 16'hFFFF) count_copy[i]++;
            span = last_copy[i] - first_copy[i];
            r.status = ST_UPDATED;
            r.slot = 6'(i);
            r.sighting_count = count_copy[i];
            r.is_persistent = (count_copy[i] >= thr_count) || (span > thr_span);
            r.entries_used = 7'(used_entries);
            return r;
         end
      end
      room = (entry_limit < TABLE_DEPTH) ? entry_limit : TABLE_DEPTH;
      if (used_entries < room) begin
         addr_copy[used_entries]  = it.device_address;
         first_copy[used_entries] = it.time_ms;
         last_copy[used_entries]  = it.time_ms;
         count_copy[used_entries] = 16'd1;
         r.status = ST_INSERTED;
         r.slot = 6'(used_entries);
         r.sighting_count = 16'd1;
         r.is_persistent = (16'd1 >= thr_count);
         used_entries++;
      end else begin
         r.status = ST_DROPPED;
      end
      r.entries_used = 7'(used_entries);
      return r;
   endfunction

   function automatic req_type make_item(logic cmd, logic [7:0] len, logic [15:0] co,
                                         logic [7:0] sub, logic [47:0] addr,
                                         logic [7:0] dbm, logic [31:0] t);
      req_type it;
      it.cmd = cmd;
      it.mfg_length = len;
      it.company_id = co;
      it.vendor_subtype = sub;
      it.device_address = addr;
      it.signal_dbm = dbm;
      it.time_ms = t;
      return it;
   endfunction

   function automatic void add_row(req_type it, bit typed, rsp_type r);
      vector_row v;
      v.item = it;
      v.typed = typed;
      v.result = r;
      directed_rows = {directed_rows, v};
   endfunction

   function automatic rsp_type make_result(logic [2:0] st, logic [1:0] k, logic [5:0] s,
                                           logic [15:0] c, logic p, logic [6:0] u);
      rsp_type r;
      r.status = st;
      r.tracker_kind = k;
      r.slot = s;
      r.sighting_count = c;
      r.is_persistent = p;
      r.entries_used = u;
      return r;
   endfunction

   // Random item: mostly trackers over the address pool, some noise and clears.
   function automatic req_type random_item();
      req_type it;
      int      pick;
      it = make_item(1'b0, 8'($urandom), 16'($urandom), 8'($urandom),
                     addr_pool[$urandom_range(0, POOL_SIZE - 1)], 8'($urandom), 32'd0);
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 19) == 0) clock_ms = clock_ms + $urandom;
      else clock_ms = clock_ms + $urandom_range(0, 200000);
      it.time_ms = clock_ms;
      if (pick < 2) begin
         it.cmd = 1'b1;
      end else if (pick < 10) begin
         // Kind-0 company with a wrong length or subtype.
         it.company_id = CO_KIND0;
         if ($urandom_range(0, 1)) it.mfg_length = 8'($urandom_range(0, 2));
         else if (it.vendor_subtype == SUB_A || it.vendor_subtype == SUB_B)
            it.vendor_subtype = 8'h00;
      end else if (pick < 18) begin
         it.mfg_length = 8'($urandom_range(0, 1));
      end else if (pick >= 25) begin
         case ($urandom_range(0, 3))
            0: begin
               it.company_id = CO_KIND0;
               it.vendor_subtype = $urandom_range(0, 1) ? SUB_A : SUB_B;
               if (it.mfg_length < 3) it.mfg_length = 8'd3;
            end
            1: it.company_id = CO_KIND1;
            2: it.company_id = CO_KIND2;
            default: it.company_id = CO_KIND3;
         endcase
         if (it.mfg_length < 2) it.mfg_length = 8'd2;
      end
      return it;
   endfunction

   // Offers one beat starting at a falling edge; returns at the falling edge after it is accepted.
   task automatic send_item(req_type it, bit typed, rsp_type typed_result);
      rsp_type r;
      req_if.valid <= 1'b1;
      req_if.payload <= it;
      do @(posedge clock); while (!req_if.ready);
      r = predict_sighting(it);
      if (typed) r = typed_result;
      expected_sightings = {expected_sightings, r};
      @(negedge clock);
   endtask

   // Drops valid for a number of cycles; a zero-length gap leaves it alone.
   task automatic idle_sender(int cycles);
      if (cycles > 0) begin
         req_if.valid <= 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   // Waits out all outstanding results, then writes one register.
   task automatic write_register(logic [1:0] idx, logic [31:0] value);
      wait (expected_sightings.size() == 0);
      repeat (TABLE_DEPTH + 8) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_COUNT_THR: thr_count = value[15:0];
         CSR_SPAN_THR:  thr_span = value;
         CSR_LIMIT:     entry_limit = value[6:0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Random traffic in bursts with gaps, and a long receiver hold-off midway.
   task automatic run_random(int items);
      int burst;
      burst = 0;
      for (int n = 0; n < items; n++) begin
         if (n == items / 2) hold_rsp = 1'b1;
         send_item(random_item(), 1'b0, '0);
         if (burst == 0) begin
            burst = $urandom_range(1, 16);
            idle_sender($urandom_range(0, 1) ? $urandom_range(1, 40) : 0);
         end else begin
            burst--;
         end
      end
      req_if.valid <= 1'b0;
   endtask

   task automatic report_mismatch(string field, longint got, longint want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
      error_count++;
   endtask

   // Result checker.
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.payload;
         if (expected_sightings.size() == 0) begin
            $display("[%0t] result beat with nothing expected", $realtime);
            error_count++;
         end else begin
            want = expected_sightings.pop_front();
            if (got.status !== want.status)
               report_mismatch("status", got.status, want.status);
            if (got.tracker_kind !== want.tracker_kind)
               report_mismatch("tracker_kind", got.tracker_kind, want.tracker_kind);
            if (got.slot !== want.slot)
               report_mismatch("slot", got.slot, want.slot);
            if (got.sighting_count !== want.sighting_count)
               report_mismatch("sighting_count", got.sighting_count, want.sighting_count);
            if (got.is_persistent !== want.is_persistent)
               report_mismatch("is_persistent", got.is_persistent, want.is_persistent);
            if (got.entries_used !== want.entries_used)
               report_mismatch("entries_used", got.entries_used, want.entries_used);
         end
      end
   end

   // Receiver: alternating windows of full speed and random stalls, plus a long hold.
   initial begin
      int rcv_cycle;
      rcv_cycle = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         rcv_cycle++;
         if (hold_rsp) begin
            rsp_if.ready <= 1'b0;
            repeat (400) @(negedge clock);
            hold_rsp = 1'b0;
         end else if ((rcv_cycle / 500) % 2 == 0) begin
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 2) != 0);
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Main sequence.
   initial begin
      error_count = 0;
      cycle_count = 0;
      hold_rsp = 1'b0;
      clock = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CSR_COUNT_THR;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      thr_count = 16'd3;
      thr_span = 32'd300000;
      entry_limit = 7'd50;
      used_entries = 0;
      clock_ms = 32'd1000;
      foreach (addr_pool[i]) addr_pool[i] = {16'($urandom), 32'($urandom)};
      addr_pool[0] = '0;
      addr_pool[1] = '1;

      // Directed rows: typed results where they follow directly from the rules.
      add_row(make_item(1'b1, 8'd0, 16'd0, 8'd0, '0, 8'd0, 32'd0), 1'b1,
              make_result(ST_CLEARED, 2'd0, 6'd0, 16'd0, 1'b0, 7'd0));
      add_row(make_item(1'b0, 8'd0, CO_KIND1, 8'd0, '1, 8'h7F, 32'd0), 1'b1,
              make_result(ST_NOT_TRACKER, 2'd0, 6'd0, 16'd0, 1'b0, 7'd0));
      add_row(make_item(1'b0, 8'd2, CO_KIND0, SUB_A, '1, 8'h80, 32'd0), 1'b1,
              make_result(ST_NOT_TRACKER, 2'd0, 6'd0, 16'd0, 1'b0, 7'd0));
      add_row(make_item(1'b0, 8'd255, 16'hFFFF, 8'hFF, '1, 8'h00, '1), 1'b1,
              make_result(ST_NOT_TRACKER, 2'd0, 6'd0, 16'd0, 1'b0, 7'd0));
      add_row(make_item(1'b0, 8'd3, CO_KIND0, SUB_B, '0, 8'h80, 32'd0), 1'b1,
              make_result(ST_INSERTED, KIND_CO0, 6'd0, 16'd1, 1'b0, 7'd1));
      add_row(make_item(1'b0, 8'd2, CO_KIND1, 8'd0, '1, 8'h7F, '1), 1'b1,
              make_result(ST_INSERTED, KIND_CO1, 6'd1, 16'd1, 1'b0, 7'd2));
      add_row(make_item(1'b0, 8'd5, CO_KIND2, 8'd0, 48'h0000_1234_5678, 8'hC4, 32'd5), 1'b0, '0);
      add_row(make_item(1'b0, 8'd9, CO_KIND3, 8'hAA, 48'h8000_0000_0001, 8'h10, 32'd6), 1'b0, '0);
      add_row(make_item(1'b0, 8'd4, CO_KIND0, SUB_A, '1, 8'hF0, 32'd7), 1'b0, '0);
      add_row(make_item(1'b0, 8'd3, CO_KIND0, SUB_A, '1, 8'hE0, 32'd8), 1'b0, '0);
      add_row(make_item(1'b0, 8'd3, CO_KIND0, 8'h13, '0, 8'hE0, 32'd9), 1'b0, '0);
      add_row(make_item(1'b0, 8'd2, CO_KIND2, 8'd0, '0, 8'h01, 32'd300000), 1'b0, '0);
      add_row(make_item(1'b0, 8'd2, CO_KIND3, 8'd0, '0, 8'h02, 32'd300001), 1'b0, '0);
      add_row(make_item(1'b0, 8'd2, CO_KIND1, 8'd0, 48'h0000_1234_5678, 8'h03, 32'd299), 1'b0, '0);
      add_row(make_item(1'b0, 8'd1, CO_KIND2, 8'd0, '0, 8'h04, 32'd10), 1'b0, '0);
      add_row(make_item(1'b1, 8'd3, CO_KIND1, 8'd0, '1, 8'h05, 32'd11), 1'b1,
              make_result(ST_CLEARED, 2'd0, 6'd0, 16'd0, 1'b0, 7'd0));
      add_row(make_item(1'b0, 8'd2, CO_KIND1, 8'd0, '1, 8'h06, 32'd12), 1'b1,
              make_result(ST_INSERTED, KIND_CO1, 6'd0, 16'd1, 1'b0, 7'd1));

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);
         if (i % 3 == 2) idle_sender($urandom_range(0, 5));
      end
      req_if.valid <= 1'b0;

      // Default settings, then a sender pause until everything has drained.
      run_random(160);
      wait (expected_sightings.size() == 0);
      @(negedge clock);

      // Smallest thresholds and the smallest table.
      write_register(CSR_COUNT_THR, 32'd1);
      write_register(CSR_SPAN_THR, 32'd0);
      write_register(CSR_LIMIT, 32'd1);
      run_random(120);

      // Largest thresholds and the full table.
      write_register(CSR_COUNT_THR, 32'd65535);
      write_register(CSR_SPAN_THR, 32'hFFFF_FFFF);
      write_register(CSR_LIMIT, 32'd64);
      run_random(220);

      // Random settings within range.
      write_register(CSR_COUNT_THR, $urandom_range(1, 8));
      write_register(CSR_SPAN_THR, $urandom_range(0, 2000000));
      write_register(CSR_LIMIT, $urandom_range(1, 64));
      run_random(150);

      write_register(CSR_COUNT_THR, $urandom_range(1, 65535));
      write_register(CSR_SPAN_THR, $urandom);
      write_register(CSR_LIMIT, $urandom_range(32, 64));
      run_random(150);

      wait (expected_sightings.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
